// ----- sv/text_to_integer_parser_assert.svh -----
`ifndef TEXT_TO_INTEGER_PARSER_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication
`define TTIP_ASSERT_IMP(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define TTIP_ASSERT_NXT(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error(msg);

`endif

// ----- sv/ttip_pkg.sv -----
package ttip_pkg;

	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned CFG_DATA_BITS = 6;

	localparam logic [5:0] BASE_RESET   = 6'd10;
	localparam logic       SIGNED_RESET = 1'b1;

	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] NO_DIGIT = 8'hFF;

	typedef enum logic [0:0] {
		CFG_BASE_SELECT = 1'b0,
		CFG_SIGNED_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       string_start;
	} text_t;

	typedef struct packed {
		logic [63:0] value_bits;
		logic [15:0] stop_index;
	} result_t;

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			v = c - 8'h37;
		end else begin
			v = NO_DIGIT;
		end
		return v;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ----- sv/ttip_engine.sv -----
module ttip_engine #(
	parameter int unsigned POSITION_BITS = ttip_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ttip_pkg::text_t   item,
	input  logic [5:0]        base_select,
	input  logic              signed_mode,
	output logic              emit,
	output ttip_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_SIGNED = 3'd2,
		PH_ZERO   = 3'd3,
		PH_HEXX   = 3'd4,
		PH_DIGITS = 3'd5
	} phase_t;

	localparam logic [POSITION_BITS-1:0] PosMax = '1;

	phase_t                   phase_q, ph, ph_n;
	logic [63:0]              acc_q, acc, acc_n;
	logic                     neg_q, neg, neg_n;
	logic [5:0]               base_q, base, base_n;
	logic [POSITION_BITS-1:0] pos_q, pos, pos_n, stop_pos;

	logic [7:0]  c, d;
	logic [63:0] mac;
	logic [5:0]  fb_base, zb_base;
	logic        first_sel;
	logic [31:0] stop_w;

	assign c   = item.char_code;
	assign d   = ttip_pkg::digit_value(c);
	assign mac = 64'(acc_q * 64'(base_q)) + 64'(d);

	always_comb begin
		ph   = item.string_start ? PH_LEAD : phase_q;
		acc  = item.string_start ? 64'd0 : acc_q;
		neg  = item.string_start ? 1'b0 : neg_q;
		base = item.string_start ? base_select : base_q;
		pos  = item.string_start ? '0 : pos_q;

		fb_base = (base == 6'd0) ? ttip_pkg::BASE_DEC : base;
		zb_base = (base == 6'd0) ? ttip_pkg::BASE_OCT : base;

		ph_n      = ph;
		acc_n     = acc;
		neg_n     = neg;
		base_n    = base;
		emit      = 1'b0;
		first_sel = 1'b0;
		res.value_bits = 64'd0;
		stop_pos  = pos;

		unique case (ph)
			PH_IDLE: begin
			end
			PH_LEAD: begin
				if (ttip_pkg::is_space(c)) begin
				end else if (c == ttip_pkg::CH_PLUS) begin
					ph_n = PH_SIGNED;
				end else if (c == ttip_pkg::CH_MINUS && signed_mode) begin
					neg_n = 1'b1;
					ph_n  = PH_SIGNED;
				end else begin
					first_sel = 1'b1;
				end
			end
			PH_SIGNED: begin
				first_sel = 1'b1;
			end
			PH_ZERO: begin
				if (c == ttip_pkg::CH_LOW_X || c == ttip_pkg::CH_UP_X) begin
					ph_n = PH_HEXX;
				end else begin
					base_n = zb_base;
					if (d < {2'b00, zb_base}) begin
						acc_n = 64'(d);
						ph_n  = PH_DIGITS;
					end else begin
						acc_n = 64'd0;
						emit  = 1'b1;
						ph_n  = PH_IDLE;
					end
				end
			end
			PH_HEXX: begin
				if (d < {2'b00, ttip_pkg::BASE_HEX}) begin
					base_n = ttip_pkg::BASE_HEX;
					acc_n  = 64'(d);
					ph_n   = PH_DIGITS;
				end else begin
					emit = 1'b1;
					ph_n = PH_IDLE;
					if (pos != PosMax && pos != '0) begin
						stop_pos = pos - POSITION_BITS'(1);
					end
				end
			end
			PH_DIGITS: begin
				if (d < {2'b00, base}) begin
					acc_n = mac;
				end else begin
					emit = 1'b1;
					ph_n = PH_IDLE;
					res.value_bits = neg ? (64'd0 - acc) : acc;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		if (first_sel) begin
			if (c == ttip_pkg::CH_ZERO &&
			    (base == 6'd0 || base == ttip_pkg::BASE_HEX)) begin
				ph_n = PH_ZERO;
			end else begin
				base_n = fb_base;
				if (d < {2'b00, fb_base}) begin
					acc_n = 64'(d);
					ph_n  = PH_DIGITS;
				end else begin
					emit     = 1'b1;
					ph_n     = PH_IDLE;
					stop_pos = '0;
				end
			end
		end

		pos_n = (ph != PH_IDLE && pos != PosMax) ? pos + POSITION_BITS'(1) : pos;

		stop_w         = 32'(stop_pos);
		res.stop_index = (stop_w > 32'h0000_FFFF) ? 16'hFFFF : stop_w[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= 64'd0;
			neg_q   <= 1'b0;
			base_q  <= 6'd0;
			pos_q   <= '0;
		end else if (fire) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			base_q  <= base_n;
			pos_q   <= pos_n;
		end
	end

endmodule

// ----- sv/text_to_integer_parser.sv -----
// Streaming strtol-style parser: one string byte per transfer on the text channel, with
// string_start set on the first byte of each string. A string gives at most one result, the value
// (two's complement, wrapping modulo 2^64) and the stop index, at its first non-digit byte;
// later bytes up to the next start flag give nothing. Throughput is one byte per cycle unless
// stalled, set by the single 64-by-6 multiply-add in the parse engine. result_valid rises once
// the ending byte, after its transfer into the input register, has been taken by the engine
// and the result register has loaded. The input stalls only while a byte waits in the input
// register behind a result that has not been taken.
// text_ready depends combinationally on result_ready. Registers: index 0 base_select
// (0 = detect from prefix, reset 10), index 1 signed_mode (reset 1); write them only while
// the block is idle. The base is taken at the first byte of each string.
module text_to_integer_parser #(
	parameter int unsigned POSITION_BITS = ttip_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               text_valid,
	output logic                               text_ready,
	input  ttip_pkg::text_t                    text_item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output ttip_pkg::result_t                  result_item,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [ttip_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic              valid_s1;
	ttip_pkg::text_t   item_s1;
	logic              out_v_q;
	ttip_pkg::result_t out_q;
	logic [5:0]        base_q;
	logic              signed_q;
	logic              out_free, fire, emit;
	ttip_pkg::result_t res;

	assign out_free   = !out_v_q || result_ready;
	assign fire       = valid_s1 && out_free;
	assign text_ready = !valid_s1 || out_free;

	assign result_valid = out_v_q;
	assign result_item  = out_q;

	ttip_engine #(
		.POSITION_BITS(POSITION_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.base_select (base_q),
		.signed_mode (signed_q),
		.emit        (emit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
			base_q   <= ttip_pkg::BASE_RESET;
			signed_q <= ttip_pkg::SIGNED_RESET;
		end else begin
			if (text_ready) begin
				valid_s1 <= text_valid;
			end
			if (out_free) begin
				out_v_q <= fire && emit;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ttip_pkg::CFG_BASE_SELECT: base_q   <= cfg_data[5:0];
					ttip_pkg::CFG_SIGNED_MODE: signed_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload: hold until the next transfer
	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			item_s1 <= text_item;
		end
		if (fire && emit) begin
			out_q <= res;
		end
	end

endmodule

// ----- sv/ttip_checker.sv -----
`include "text_to_integer_parser_assert.svh"

module ttip_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              text_ready,
	input logic              result_valid,
	input logic              result_ready,
	input ttip_pkg::result_t result_item
);

	`TTIP_ASSERT_IMP(a_stall_only_on_full_output, clk, arst_n, !text_ready, result_valid && !result_ready, "text_ready low without a stalled result")
	`TTIP_ASSERT_IMP(a_no_digit_gives_zero, clk, arst_n, result_valid && result_item.stop_index == 16'd0, result_item.value_bits == 64'd0, "stop index zero with nonzero value")
	`TTIP_ASSERT_NXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped before transfer")
	`TTIP_ASSERT_NXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(result_item), "stalled result changed")

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_ready   (text_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_item  (result_item)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import ttip_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGN,
		PH_ZERO,
		PH_HEXX,
		PH_DIGITS
	} parse_phase_t;

	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam int unsigned IDLE_PCT = 34;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned TIMEOUT_CYCLES = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_ready;
	text_t text_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result_item;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_BASE_SELECT;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	text_to_integer_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_item(text_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predicted parser state and registers
	logic [5:0] base_reg = BASE_RESET;
	logic sign_reg = SIGNED_RESET;
	parse_phase_t phase = PH_IDLE;
	logic [63:0] accum = '0;
	logic negative = 1'b0;
	logic [5:0] cur_base = '0;
	logic [15:0] position = '0;

	result_t expected_q[$];
	int unsigned errors = 0;
	int unsigned bytes_accepted = 0;
	int unsigned bytes_offered = 0;
	int unsigned results_checked = 0;
	int unsigned settings_used = 0;

	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;
	bit hold_off_req = 1'b0;

	function automatic logic [7:0] char_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c - "0";
		end
		if (c >= "a" && c <= "z") begin
			return c - "a" + 8'd10;
		end
		if (c >= "A" && c <= "Z") begin
			return c - "A" + 8'd10;
		end
		return NO_DIGIT;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic finish_number(input logic [63:0] v, input logic [15:0] stop,
		output bit got, output result_t r);
		r.value_bits = v;
		r.stop_index = stop;
		got = 1'b1;
		phase = PH_IDLE;
	endtask

	task automatic digit_step(input logic [7:0] c, output bit got, output result_t r);
		logic [7:0] d;
		d = char_digit(c);
		got = 1'b0;
		r = '0;
		if (d < {2'b00, cur_base}) begin
			accum = accum * {58'd0, cur_base} + {56'd0, d};
			phase = PH_DIGITS;
		end else begin
			finish_number(negative ? 64'd0 - accum : accum, position, got, r);
		end
	endtask

	task automatic first_step(input logic [7:0] c, output bit got, output result_t r);
		logic [7:0] d;
		got = 1'b0;
		r = '0;
		if (c == CH_ZERO && (cur_base == 6'd0 || cur_base == BASE_HEX)) begin
			phase = PH_ZERO;
		end else begin
			if (cur_base == 6'd0) begin
				cur_base = BASE_DEC;
			end
			d = char_digit(c);
			if (d < {2'b00, cur_base}) begin
				accum = {56'd0, d};
				phase = PH_DIGITS;
			end else begin
				finish_number(64'd0, 16'd0, got, r);
			end
		end
	endtask

	task automatic parse_byte(input text_t t, output bit got, output result_t r);
		logic [7:0] c;
		logic [15:0] stop;
		bit live;
		c = t.char_code;
		got = 1'b0;
		r = '0;
		if (t.string_start) begin
			phase = PH_LEAD;
			accum = '0;
			negative = 1'b0;
			cur_base = base_reg;
			position = '0;
		end
		live = phase != PH_IDLE;
		case (phase)
			PH_LEAD: begin
				if (is_blank(c)) begin
				end else if (c == CH_PLUS) begin
					phase = PH_SIGN;
				end else if (c == CH_MINUS && sign_reg) begin
					negative = 1'b1;
					phase = PH_SIGN;
				end else begin
					first_step(c, got, r);
				end
			end
			PH_SIGN: begin
				first_step(c, got, r);
			end
			PH_ZERO: begin
				if (c == CH_LOW_X || c == CH_UP_X) begin
					phase = PH_HEXX;
				end else begin
					if (cur_base == 6'd0) begin
						cur_base = BASE_OCT;
					end
					accum = '0;
					digit_step(c, got, r);
				end
			end
			PH_HEXX: begin
				if (char_digit(c) < 8'd16) begin
					cur_base = BASE_HEX;
					accum = {56'd0, char_digit(c)};
					phase = PH_DIGITS;
				end else begin
					stop = position;
					if (stop < POS_MAX && stop > 16'd0) begin
						stop = stop - 16'd1;
					end
					finish_number(64'd0, stop, got, r);
				end
			end
			PH_DIGITS: begin
				digit_step(c, got, r);
			end
			default: begin
				phase = PH_IDLE;
			end
		endcase
		if (live && position < POS_MAX) begin
			position = position + 16'd1;
		end
	endtask

	always @(posedge clk) begin : monitor
		result_t want;
		result_t next_result;
		bit produced;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_checked++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: value_bits %h stop_index %0d",
						$time, result_item.value_bits, result_item.stop_index);
				end else begin
					want = expected_q.pop_front();
					if (result_item.value_bits !== want.value_bits) begin
						errors++;
						$display("%0t: value_bits expected %h actual %h",
							$time, want.value_bits, result_item.value_bits);
					end
					if (result_item.stop_index !== want.stop_index) begin
						errors++;
						$display("%0t: stop_index expected %0d actual %0d",
							$time, want.stop_index, result_item.stop_index);
					end
				end
			end
			if (text_valid && text_ready) begin
				parse_byte(text_item, produced, next_result);
				if (produced) begin
					expected_q.push_back(next_result);
				end
				bytes_accepted++;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_BASE_SELECT) begin
					base_reg = cfg_data;
				end else begin
					sign_reg = cfg_data[0];
				end
			end
		end
	end

	// result sink: random stalls, plus a long hold-off on request
	initial begin : sink
		int unsigned hold_count;
		hold_count = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_count = HOLD_OFF_CYCLES;
			end
			if (hold_count > 0) begin
				result_ready <= 1'b0;
				hold_count--;
			end else begin
				result_ready <= sink_calm || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic st);
		while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_item <= '{char_code: c, string_start: st};
		text_valid <= 1'b1;
		@(posedge clk);
		while (!text_ready) begin
			@(posedge clk);
		end
		bytes_offered++;
	endtask

	task automatic send_text(input string s, input bit terminate);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == 0);
		end
		if (terminate) begin
			send_byte(8'h00, s.len() == 0);
		end
	endtask

	// drain, then write both registers while the block is idle
	task automatic set_config(input logic [5:0] base, input logic sgn);
		text_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE_SELECT;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_SIGNED_MODE;
		cfg_data <= CFG_DATA_BITS'(sgn);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random_string(input logic [5:0] base);
		logic [7:0] bytes_q[$];
		int unsigned n, lim, v, i, pick;
		bit restart;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
			return;
		end
		n = $urandom_range(0, 2);
		for (i = 0; i < n; i++) begin
			v = $urandom_range(8, 13);
			bytes_q.push_back(v == 8 ? CH_SPACE : 8'(v));
		end
		pick = $urandom_range(0, 3);
		if (pick == 0) begin
			bytes_q.push_back(CH_PLUS);
		end else if (pick == 1) begin
			bytes_q.push_back(CH_MINUS);
		end
		pick = $urandom_range(0, 5);
		if (pick <= 2) begin
			bytes_q.push_back(CH_ZERO);
		end
		if (pick == 0) begin
			bytes_q.push_back(CH_LOW_X);
		end else if (pick == 1) begin
			bytes_q.push_back(CH_UP_X);
		end
		n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 24) : $urandom_range(0, 8);
		lim = base == 6'd0 ? 16 : (base > 6'd36 ? 36 : base);
		for (i = 0; i < n; i++) begin
			v = $urandom_range(0, lim - 1);
			if (v < 10) begin
				bytes_q.push_back(8'(CH_ZERO + v));
			end else begin
				bytes_q.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
			end
		end
		restart = $urandom_range(0, 9) == 0;
		if (!restart) begin
			bytes_q.push_back($urandom_range(0, 4) < 3 ? 8'h00 : 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					bytes_q.push_back(8'($urandom_range(0, 255)));
				end
			end
		end
		for (i = 0; i < bytes_q.size(); i++) begin
			send_byte(bytes_q[i], i == 0);
		end
	endtask

	task automatic test_reset_defaults();
		send_text(" \t-42z", 1'b1);
		send_text("+17", 1'b1);
		send_text("-", 1'b1);
		send_text("", 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_text("12", 1'b0);
		send_text("34", 1'b1);
		send_byte("9", 1'b0);
	endtask

	task automatic test_prefixes();
		set_config(6'd0, 1'b1);
		send_text("0x1f", 1'b1);
		send_text("0Xg", 1'b1);
		send_text("017", 1'b1);
		send_text("09", 1'b1);
		set_config(BASE_HEX, 1'b0);
		send_text("0xF", 1'b1);
		send_text("-5", 1'b1);
	endtask

	task automatic test_odd_bases();
		set_config(6'd1, 1'b1);
		send_text("0010", 1'b1);
		set_config(6'd63, 1'b0);
		send_text("Zz~", 1'b1);
		set_config(6'd36, 1'b1);
		send_text("-zZ", 1'b1);
	endtask

	task automatic test_random_settings();
		logic [5:0] bases [9];
		logic signs [9];
		int unsigned k, start;
		bases = '{BASE_DEC, 6'd0, BASE_HEX, 6'd36, 6'd1, 6'd63, 6'd2, 6'd37,
			6'($urandom_range(0, 63))};
		signs = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
		for (k = 0; k < 9; k++) begin
			set_config(bases[k], signs[k]);
			start = bytes_offered;
			while (bytes_offered - start < 20) begin
				send_random_string(bases[k]);
			end
			send_byte(8'h00, 1'b0);
		end
	endtask

	task automatic test_backpressure();
		int unsigned k;
		set_config(BASE_DEC, 1'b1);
		sender_calm = 1'b1;
		hold_off_req = 1'b1;
		for (k = 0; k < 30; k++) begin
			send_text("7", 1'b1);
		end
		sender_calm = 1'b0;
	endtask

	task automatic test_no_idle();
		int unsigned start;
		set_config(6'd0, 1'b1);
		sender_calm = 1'b1;
		sink_calm = 1'b1;
		start = bytes_offered;
		while (bytes_offered - start < 50) begin
			send_random_string(6'd0);
		end
		send_byte(8'h00, 1'b0);
		sender_calm = 1'b0;
		sink_calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_prefixes();
		test_odd_bases();
		test_random_settings();
		test_backpressure();
		test_no_idle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		$display("Parsed %0d bytes into %0d checked results over %0d register settings,",
			bytes_accepted, results_checked, settings_used);
		$display("including prefixes, odd bases, overflow, restarts and back-pressure.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("Timeout with %0d results outstanding", expected_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
